@@ src/assert_macros.svh @@
// Assertion macros used by the buffer pool ownership manager
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BPOM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bpom_pkg.sv @@
// Types, codes and helpers for the buffer pool ownership manager
package bpom_pkg;

    localparam int ID_SPACE = 16;
    localparam int ID_W     = 4;
    localparam int CNT_W    = 5;

    typedef enum logic [1:0] {
        OWN_EMPTY     = 2'd0,
        OWN_LOADING   = 2'd1,
        OWN_LOADED    = 2'd2,
        OWN_UNLOADING = 2'd3
    } own_t;

    typedef enum logic [1:0] {
        KIND_TAKE_FREE   = 2'd0,
        KIND_LOADED      = 2'd1,
        KIND_TAKE_LOADED = 2'd2,
        KIND_UNLOADED    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_CLOSED = 2'd1,
        STAT_NONE   = 2'd2,
        STAT_WRONG  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } fsm_t;

    localparam logic REG_POOL_SIZE = 1'b0;
    localparam logic REG_POOL_OPEN = 1'b1;

    // zero acts as one, anything above the limit is clamped to it
    function automatic logic [CNT_W-1:0] eff_size_f(input logic [CNT_W-1:0] s,
                                                    input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] r;
        r = s;
        if (s == '0)
            r = CNT_W'(1);
        else if (s > lim)
            r = lim;
        return r;
    endfunction

endpackage

@@ src/buffer_pool_ownership_manager.sv @@
// Buffer pool ownership manager: free stack, loaded FIFO and owner table in RAM
// Usage:
//   Input channel (in_valid/in_ready) carries a request word: kind and buffer_id.
//   kind 0 takes a free id, 1 reports an id loaded, 2 takes the oldest loaded id,
//   3 reports an id unloaded. Output channel (out_valid/out_ready) returns one
//   word per request: status, granted_id, pool_full, pool_empty, loaded_count.
//   Config port: cfg_we with cfg_addr 0 (pool_size) or 1 (pool_open) and cfg_data;
//   every write reinitialises the pool to all ids free. Write only while idle.
// Timing:
//   A request is accepted when in_valid and in_ready are high; its RAM reads
//   (stack top, FIFO head, owner entry) land the next cycle, where the word is
//   resolved and written back and the result loaded into the output register,
//   raising out_valid. The next request waits for that write-back (read-then-write).
//   in_ready is low during the write-back cycle, which acts as the interlock.
// Reset:
//   pool_size 16 (clamped to MAX_BUFFERS), pool closed, all ids free; the
//   stack and owner tables use per-entry valid bits, so no clearing pass.
// Stall:
//   A held result keeps out_valid high; the next request may be accepted and
//   waits in the write-back cycle until the output register frees.
`include "assert_macros.svh"

module buffer_pool_ownership_manager
    import bpom_pkg::*;
#(
    parameter int MAX_BUFFERS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       kind,
    input  logic [ID_W-1:0]  buffer_id,

    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [ID_W-1:0]  granted_id,
    output logic             pool_full,
    output logic             pool_empty,
    output logic [CNT_W-1:0] loaded_count,

    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int LIMIT_INT = (MAX_BUFFERS > ID_SPACE) ? ID_SPACE : MAX_BUFFERS;
    localparam logic [CNT_W-1:0] SIZE_LIMIT = CNT_W'(LIMIT_INT);

    // memories
    logic [ID_W-1:0] stack_mem [ID_SPACE];
    logic [ID_W-1:0] fifo_mem  [ID_SPACE];
    logic [1:0]      own_mem   [ID_SPACE];

    fsm_t              fsm_reg, fsm_next;
    logic [CNT_W-1:0]  pool_size_reg, pool_size_next;
    logic              pool_open_reg, pool_open_next;
    logic [CNT_W-1:0]  free_top_reg, free_top_next;
    logic [ID_W-1:0]   ready_head_reg, ready_head_next;
    logic [ID_W-1:0]   ready_tail_reg, ready_tail_next;
    logic [CNT_W-1:0]  ready_count_reg, ready_count_next;
    logic [ID_SPACE-1:0] stack_vld_reg, stack_vld_next;
    logic [ID_SPACE-1:0] own_vld_reg, own_vld_next;

    // captured request and registered read data
    kind_t             kind_reg;
    logic [ID_W-1:0]   bid_reg;
    logic [ID_W-1:0]   stack_rd_reg;
    logic [ID_W-1:0]   fifo_rd_reg;
    logic [1:0]        own_rd_reg;
    logic              stack_rv_reg;
    logic              own_rv_reg;

    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [ID_W-1:0]   grant_reg, grant_next;
    logic              full_reg, empty_reg;
    logic [CNT_W-1:0]  count_out_reg;

    logic              accept;
    logic              done;
    logic [CNT_W-1:0]  eff_size;
    logic [CNT_W-1:0]  cfg_size;
    logic [ID_W-1:0]   top_idx;
    logic [ID_W-1:0]   stack_id;
    own_t              own_cur;

    logic              stack_we;
    logic [ID_W-1:0]   stack_wd;
    logic              fifo_we;
    logic              own_we;
    logic [ID_W-1:0]   own_wa;
    own_t              own_wd;

    logic [CNT_W:0]    held_ids;
    logic              closed_done;
    logic [2*CNT_W+ID_W-1:0] ptr_state;

    assign in_ready  = (fsm_reg == FSM_IDLE);
    assign accept    = in_valid && in_ready;
    assign done      = (fsm_reg == FSM_EXEC) && (!out_valid_reg || out_ready);
    assign eff_size  = eff_size_f(pool_size_reg, SIZE_LIMIT);
    assign top_idx   = ID_W'(free_top_reg - CNT_W'(1));
    assign stack_id  = stack_rv_reg ? stack_rd_reg : top_idx;
    assign own_cur   = own_rv_reg ? own_t'(own_rd_reg) : OWN_EMPTY;

    always_comb
    begin
        pool_size_next   = pool_size_reg;
        pool_open_next   = pool_open_reg;
        free_top_next    = free_top_reg;
        ready_head_next  = ready_head_reg;
        ready_tail_next  = ready_tail_reg;
        ready_count_next = ready_count_reg;
        stack_vld_next   = stack_vld_reg;
        own_vld_next     = own_vld_reg;
        status_next      = STAT_OK;
        grant_next       = '0;
        stack_we         = 1'b0;
        stack_wd         = bid_reg;
        fifo_we          = 1'b0;
        own_we           = 1'b0;
        own_wa           = bid_reg;
        own_wd           = OWN_EMPTY;
        cfg_size         = pool_size_reg;

        if (!pool_open_reg)
        begin
            status_next = STAT_CLOSED;
        end
        else
        begin
            unique case (kind_reg)
                KIND_TAKE_FREE:
                begin
                    if (free_top_reg == '0)
                        status_next = STAT_NONE;
                    else
                    begin
                        free_top_next = free_top_reg - CNT_W'(1);
                        grant_next    = stack_id;
                        own_we        = 1'b1;
                        own_wa        = stack_id;
                        own_wd        = OWN_LOADING;
                    end
                end
                KIND_LOADED:
                begin
                    if (own_cur != OWN_LOADING || ready_count_reg >= CNT_W'(ID_SPACE))
                        status_next = STAT_WRONG;
                    else
                    begin
                        own_we           = 1'b1;
                        own_wd           = OWN_LOADED;
                        fifo_we          = 1'b1;
                        ready_tail_next  = ready_tail_reg + ID_W'(1);
                        ready_count_next = ready_count_reg + CNT_W'(1);
                    end
                end
                KIND_TAKE_LOADED:
                begin
                    if (ready_count_reg == '0)
                        status_next = STAT_NONE;
                    else
                    begin
                        grant_next       = fifo_rd_reg;
                        ready_head_next  = ready_head_reg + ID_W'(1);
                        ready_count_next = ready_count_reg - CNT_W'(1);
                        own_we           = 1'b1;
                        own_wa           = fifo_rd_reg;
                        own_wd           = OWN_UNLOADING;
                    end
                end
                KIND_UNLOADED:
                begin
                    if (own_cur != OWN_UNLOADING || free_top_reg >= CNT_W'(ID_SPACE))
                        status_next = STAT_WRONG;
                    else
                    begin
                        own_we        = 1'b1;
                        own_wd        = OWN_EMPTY;
                        stack_we      = 1'b1;
                        free_top_next = free_top_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STAT_WRONG;
                end
            endcase
        end

        if (!done)
        begin
            free_top_next    = free_top_reg;
            ready_head_next  = ready_head_reg;
            ready_tail_next  = ready_tail_reg;
            ready_count_next = ready_count_reg;
            stack_we         = 1'b0;
            fifo_we          = 1'b0;
            own_we           = 1'b0;
        end
        if (stack_we)
            stack_vld_next[free_top_reg[ID_W-1:0]] = 1'b1;
        if (own_we)
            own_vld_next[own_wa] = 1'b1;

        // any register write reinitialises the pool
        if (cfg_we)
        begin
            if (cfg_addr == REG_POOL_SIZE)
            begin
                pool_size_next = cfg_data;
                cfg_size       = cfg_data;
            end
            else
                pool_open_next = cfg_data[0];
            free_top_next    = eff_size_f(cfg_size, SIZE_LIMIT);
            ready_head_next  = '0;
            ready_tail_next  = '0;
            ready_count_next = '0;
            stack_vld_next   = '0;
            own_vld_next     = '0;
        end
    end

    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE: if (accept) fsm_next = FSM_EXEC;
            FSM_EXEC: if (done)   fsm_next = FSM_IDLE;
            default:              fsm_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= FSM_IDLE;
            pool_size_reg   <= CNT_W'(ID_SPACE);
            pool_open_reg   <= 1'b0;
            free_top_reg    <= SIZE_LIMIT;
            ready_head_reg  <= '0;
            ready_tail_reg  <= '0;
            ready_count_reg <= '0;
            stack_vld_reg   <= '0;
            own_vld_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fsm_reg         <= fsm_next;
            pool_size_reg   <= pool_size_next;
            pool_open_reg   <= pool_open_next;
            free_top_reg    <= free_top_next;
            ready_head_reg  <= ready_head_next;
            ready_tail_reg  <= ready_tail_next;
            ready_count_reg <= ready_count_next;
            stack_vld_reg   <= stack_vld_next;
            own_vld_reg     <= own_vld_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // request capture and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind_t'(kind);
            bid_reg      <= buffer_id;
            stack_rv_reg <= stack_vld_reg[ID_W'(free_top_reg - CNT_W'(1))];
            own_rv_reg   <= own_vld_reg[buffer_id];
        end
        if (done)
        begin
            status_reg    <= status_next;
            grant_reg     <= grant_next;
            full_reg      <= (free_top_next == '0);
            empty_reg     <= (ready_count_next == '0);
            count_out_reg <= ready_count_next;
        end
    end

    // RAMs: reads issued on accept, writes in the write-back cycle
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[free_top_reg[ID_W-1:0]] <= stack_wd;
        if (accept)
            stack_rd_reg <= stack_mem[ID_W'(free_top_reg - CNT_W'(1))];
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
            fifo_mem[ready_tail_reg] <= bid_reg;
        if (accept)
            fifo_rd_reg <= fifo_mem[ready_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
            own_mem[own_wa] <= own_wd;
        if (accept)
            own_rd_reg <= own_mem[buffer_id];
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign granted_id   = grant_reg;
    assign pool_full    = full_reg;
    assign pool_empty   = empty_reg;
    assign loaded_count = count_out_reg;

    assign held_ids    = {1'b0, free_top_reg} + {1'b0, ready_count_reg};
    assign closed_done = done && !pool_open_reg && !cfg_we;
    assign ptr_state   = {free_top_reg, ready_count_reg, ready_head_reg};

    `BPOM_ASSERT_SAME(a_pool_conserved, 1'b1, held_ids <= {1'b0, eff_size}, "pool overcommitted")
    `BPOM_ASSERT_NEXT(a_accept_interlock, accept, !in_ready, "accept during write-back")
    `BPOM_ASSERT_NEXT(a_closed_no_change, closed_done, $stable(ptr_state), "closed pool changed")

endmodule
